/* rtl/aes_ctr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CTR shared definitions
// S-box table, round helpers and register indexes for the counter-mode cipher.
// ----------------------------------------------------------------------------
package aes_ctr_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int KEY_WORDS  = 4 * (NUM_ROUNDS + 1);

    typedef logic [127:0] t_block;
    typedef logic [4:0]   t_count;

    typedef enum logic [1:0] {
        REG_KEY_HIGH   = 2'd0,
        REG_KEY_LOW    = 2'd1,
        REG_NONCE_HIGH = 2'd2,
        REG_NONCE_LOW  = 2'd3
    } t_reg_index;

    // Sideband that travels down the round chain next to the state.
    typedef struct packed {
        logic   valid;
        t_block data;
        t_count nbytes;
    } t_side;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        unique case (i)
            4'd0: r = 8'h01; 4'd1: r = 8'h02; 4'd2: r = 8'h04; 4'd3: r = 8'h08;
            4'd4: r = 8'h10; 4'd5: r = 8'h20; 4'd6: r = 8'h40; 4'd7: r = 8'h80;
            4'd8: r = 8'h1b; 4'd9: r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Next round key from the previous one; byte 0 sits in bits 127:120.
    function automatic t_block next_key(input t_block k, input logic [3:0] rnd);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rcon(rnd), 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

/* rtl/aes_ctr_round.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CTR round cell
// One cipher round plus its key step; registers state, key and sideband.
// ----------------------------------------------------------------------------
module aes_ctr_round
    import aes_ctr_pkg::*;
#(
    parameter logic [3:0] RND = 4'd0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  t_block i_state,
    input  t_block i_key,
    input  t_side  i_side,
    output t_block o_state,
    output t_block o_key,
    output t_side  o_side
);

    localparam bit LAST = (RND == 4'(NUM_ROUNDS - 1));

    t_block r_state, r_key;
    t_side  r_side;
    t_block n_state, n_key;
    t_block sb, sr, mc;

    always_comb begin
        n_key = next_key(i_key, RND);
        for (int i = 0; i < 16; i++) begin
            sb[127 - 8*i -: 8] = sbox(i_state[127 - 8*i -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sr[127 - 8*(r + 4*c) -: 8] = sb[127 - 8*(r + 4*((c + r) % 4)) -: 8];
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sr[127 - 32*c -: 8];
            a1 = sr[119 - 32*c -: 8];
            a2 = sr[111 - 32*c -: 8];
            a3 = sr[103 - 32*c -: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            mc[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        n_state = (LAST ? sr : mc) ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side.valid <= i_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state       <= n_state;
            r_key         <= n_key;
            r_side.data   <= i_side.data;
            r_side.nbytes <= i_side.nbytes;
        end
    end

    assign o_state = r_state;
    assign o_key   = r_key;
    assign o_side  = r_side;

endmodule

/* rtl/aes128_ctr_stream_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 counter-mode stream cipher
// XORs data with the AES-128 encryption of a running counter; zeroes unused bytes.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | i_valid / o_stall   | i_data_high, i_data_low, i_valid_bytes,
//           |                     | i_first
//  output   | o_valid / i_stall   | o_out_high, o_out_low, o_out_valid_bytes
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One block per cycle when not stalled; a block passes the counter/whitening
// stage, ten round cells, and the output register. The chain is one pipeline
// that moves as a whole whenever the output register is free or being emptied.
// Round keys are computed on the fly in each cell, so a key write needs no
// expansion pass. Reset clears counter, key, nonce and all valid flags.
// ----------------------------------------------------------------------------
module aes128_ctr_stream_cipher
    import aes_ctr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_high,
    input  logic [63:0] i_data_low,
    input  logic [4:0]  i_valid_bytes,
    input  logic        i_first,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_out_high,
    output logic [63:0] o_out_low,
    output logic [4:0]  o_out_valid_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_block r_key, r_nonce, r_ctr;
    t_block r_s0, r_k0;
    t_side  r_side0;
    t_block st   [NUM_ROUNDS+1];
    t_block ky   [NUM_ROUNDS+1];
    t_side  sd   [NUM_ROUNDS+1];
    logic   r_ov;
    logic [127:0] r_out;
    t_count r_onb;
    logic   en, acc;
    t_block ctr_use, ks, mask, res;
    t_count nb;

    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;
    assign acc     = i_valid && en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_nonce <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_KEY_HIGH:   r_key[127:64]   <= i_cfg_data;
                REG_KEY_LOW:    r_key[63:0]     <= i_cfg_data;
                REG_NONCE_HIGH: r_nonce[127:64] <= i_cfg_data;
                REG_NONCE_LOW:  r_nonce[63:0]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ctr_use = i_first ? r_nonce : r_ctr;
    assign nb      = (i_valid_bytes > 5'd16) ? 5'd16 : i_valid_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr         <= '0;
            r_side0.valid <= 1'b0;
        end else if (en) begin
            r_side0.valid <= i_valid;
            if (acc) begin
                r_ctr <= ctr_use + 128'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0           <= ctr_use ^ r_key;
            r_k0           <= r_key;
            r_side0.data   <= {i_data_high, i_data_low};
            r_side0.nbytes <= nb;
        end
    end

    assign st[0] = r_s0;
    assign ky[0] = r_k0;
    assign sd[0] = r_side0;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes_ctr_round #(.RND(4'(g))) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_state (st[g]),
            .i_key   (ky[g]),
            .i_side  (sd[g]),
            .o_state (st[g+1]),
            .o_key   (ky[g+1]),
            .o_side  (sd[g+1])
        );
    end

    assign ks = st[NUM_ROUNDS];
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            mask[127 - 8*i -: 8] = (5'(i) < sd[NUM_ROUNDS].nbytes) ? 8'hff : 8'h00;
        end
        res = (sd[NUM_ROUNDS].data ^ ks) & mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= sd[NUM_ROUNDS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= res;
            r_onb <= sd[NUM_ROUNDS].nbytes;
        end
    end

    assign o_valid           = r_ov;
    assign o_out_high        = r_out[127:64];
    assign o_out_low         = r_out[63:0];
    assign o_out_valid_bytes = r_onb;

endmodule
